// File: rtl/lsbc_pkg.sv
// ----------------------------------------------------------------------------
// lsbc_pkg: shared types and constants for the segment clipper
// Widths of the coordinate, ratio and parameter paths, the beat structs, the
// per-edge divider lane record and the lane setup function.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbc_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;   // differences of two coordinates
   localparam int U_BITS     = FRAC_BITS + 1;    // u in [0, 1.0]
   localparam int QUO_BITS   = FRAC_BITS + 2;    // raw quotient, one extra round bit
   localparam int DVS_BITS   = DIFF_BITS + 1;    // divisor is 2*|p|
   localparam int REM_BITS   = DVS_BITS + 1;
   localparam int R_BITS     = QUO_BITS + 2;     // signed ratio
   localparam int PROD_BITS  = DIFF_BITS + U_BITS;
   localparam int NUM_CELLS  = QUO_BITS;         // one quotient bit per cell
   localparam int NUM_EDGES  = 4;

   localparam logic [U_BITS-1:0] U_ONE = U_BITS'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      REG_X_MIN = 2'd0,
      REG_Y_MIN = 2'd1,
      REG_X_MAX = 2'd2,
      REG_Y_MAX = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                         accepted;
      logic signed [COORD_BITS-1:0] clipped_start_x;
      logic signed [COORD_BITS-1:0] clipped_start_y;
      logic signed [COORD_BITS-1:0] clipped_end_x;
      logic signed [COORD_BITS-1:0] clipped_end_y;
   } rsp_type;

   // one edge test in flight through the divider row
   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [DVS_BITS-1:0] dvs;
      logic [QUO_BITS-1:0] quo;
      logic                sat;     // |q| >= 2|p|: ratio is at least 2.0
      logic                pneg;
      logic                pzero;
      logic                qneg;
   } lane_type;

   typedef struct packed {
      lane_type [NUM_EDGES-1:0]    lane;
      logic signed [DIFF_BITS-1:0] sx;
      logic signed [DIFF_BITS-1:0] sy;
      logic signed [DIFF_BITS-1:0] dx;
      logic signed [DIFF_BITS-1:0] dy;
   } item_type;

   function automatic logic [DIFF_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] v);
      mag = v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
   endfunction

   // set up one edge: divide |q| by |p|
   function automatic lane_type make_lane(input logic signed [DIFF_BITS-1:0] p,
                                          input logic signed [DIFF_BITS-1:0] q);
      lane_type            l;
      logic [DIFF_BITS-1:0] aq;
      logic [DIFF_BITS-1:0] ap;
      aq      = mag(q);
      ap      = mag(p);
      l.rem   = REM_BITS'(aq);
      l.dvs   = {ap, 1'b0};
      l.quo   = '0;
      l.sat   = ({1'b0, aq} >= {ap, 1'b0});
      l.pneg  = p[DIFF_BITS-1];
      l.pzero = (p == '0);
      l.qneg  = q[DIFF_BITS-1];
      make_lane = l;
   endfunction

endpackage

`default_nettype wire

// File: rtl/lsbc_cell.sv
// ----------------------------------------------------------------------------
// lsbc_cell: one restoring division step for every edge lane
// Shifts each partial remainder, subtracts the divisor where it fits and
// appends one quotient bit; the rest of the beat rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbc_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire lsbc_pkg::item_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output lsbc_pkg::item_type     out_data
);

   logic               valid_ff;
   lsbc_pkg::item_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // division step per lane
   always_comb begin
      logic [lsbc_pkg::REM_BITS-1:0] t;
      logic                          ge;
      data_in = in_data;
      for (int i = 0; i < lsbc_pkg::NUM_EDGES; i++) begin
         t  = {in_data.lane[i].rem[lsbc_pkg::REM_BITS-2:0], 1'b0};
         ge = (t >= lsbc_pkg::REM_BITS'(in_data.lane[i].dvs));
         data_in.lane[i].rem = ge ? t - lsbc_pkg::REM_BITS'(in_data.lane[i].dvs) : t;
         data_in.lane[i].quo = {in_data.lane[i].quo[lsbc_pkg::QUO_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lsbc_tail.sv
// ----------------------------------------------------------------------------
// lsbc_tail: edge decisions, endpoint scaling and result register
// Stage A runs the left, right, bottom and top edge tests in order, stage B
// forms |d|*u, stage C rounds, adds the start point and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbc_tail (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire lsbc_pkg::item_type in_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lsbc_pkg::rsp_type       rsp_data
);

   localparam int UB = lsbc_pkg::U_BITS;
   localparam int DB = lsbc_pkg::DIFF_BITS;
   localparam int PB = lsbc_pkg::PROD_BITS;
   localparam int RB = lsbc_pkg::R_BITS;

   typedef struct packed {
      logic                 ok;
      logic [UB-1:0]        u1;
      logic [UB-1:0]        u2;
      logic signed [DB-1:0] sx;
      logic signed [DB-1:0] sy;
      logic signed [DB-1:0] dx;
      logic signed [DB-1:0] dy;
   } sta_type;

   typedef struct packed {
      logic                 ok;
      logic [PB-1:0]        p1x;
      logic [PB-1:0]        p1y;
      logic [PB-1:0]        p2x;
      logic [PB-1:0]        p2y;
      logic                 nx;
      logic                 ny;
      logic signed [DB-1:0] sx;
      logic signed [DB-1:0] sy;
   } stb_type;

   logic    a_valid_ff, b_valid_ff, c_valid_ff;
   logic    a_ready, b_ready, c_ready;
   sta_type a_ff, a_in;
   stb_type b_ff, b_in;
   lsbc_pkg::rsp_type c_ff, c_in;

   assign c_ready   = !c_valid_ff || rsp_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign in_ready  = a_ready;
   assign rsp_valid = c_valid_ff;
   assign rsp_data  = c_ff;

   // stage A: edge tests left, right, bottom, top
   always_comb begin
      logic [lsbc_pkg::QUO_BITS:0]   qp1;
      logic [lsbc_pkg::QUO_BITS-1:0] m;
      logic [lsbc_pkg::QUO_BITS-1:0] mc;
      logic signed [RB-1:0]          r;
      logic signed [RB-1:0]          su1;
      logic signed [RB-1:0]          su2;
      logic                          ok;
      logic [UB-1:0]                 u1;
      logic [UB-1:0]                 u2;
      ok = 1'b1;
      u1 = '0;
      u2 = lsbc_pkg::U_ONE;
      for (int i = 0; i < lsbc_pkg::NUM_EDGES; i++) begin
         qp1 = {1'b0, in_data.lane[i].quo} + 1'b1;
         m   = in_data.lane[i].sat ? (lsbc_pkg::QUO_BITS'(lsbc_pkg::U_ONE) << 1)
                                   : qp1[lsbc_pkg::QUO_BITS:1];
         mc  = (m > lsbc_pkg::QUO_BITS'(lsbc_pkg::U_ONE))
               ? lsbc_pkg::QUO_BITS'(lsbc_pkg::U_ONE) : m;
         r   = (in_data.lane[i].qneg ^ in_data.lane[i].pneg)
               ? -$signed(RB'(mc)) : $signed(RB'(m));
         su1 = $signed(RB'(u1));
         su2 = $signed(RB'(u2));
         if (ok) begin
            if (in_data.lane[i].pzero) begin
               if (in_data.lane[i].qneg) ok = 1'b0;
            end else if (in_data.lane[i].pneg) begin
               if (r > su2) ok = 1'b0;
               else if (r > su1) u1 = r[UB-1:0];
            end else begin
               if (r < su1) ok = 1'b0;
               else if (r < su2) u2 = r[UB-1:0];
            end
         end
      end
      a_in.ok = ok;
      a_in.u1 = u1;
      a_in.u2 = u2;
      a_in.sx = in_data.sx;
      a_in.sy = in_data.sy;
      a_in.dx = in_data.dx;
      a_in.dy = in_data.dy;
   end

   // stage B: magnitude products
   always_comb begin
      logic [DB-1:0] adx;
      logic [DB-1:0] ady;
      adx     = lsbc_pkg::mag(a_ff.dx);
      ady     = lsbc_pkg::mag(a_ff.dy);
      b_in.ok  = a_ff.ok;
      b_in.p1x = PB'(adx) * PB'(a_ff.u1);
      b_in.p1y = PB'(ady) * PB'(a_ff.u1);
      b_in.p2x = PB'(adx) * PB'(a_ff.u2);
      b_in.p2y = PB'(ady) * PB'(a_ff.u2);
      b_in.nx  = a_ff.dx[DB-1];
      b_in.ny  = a_ff.dy[DB-1];
      b_in.sx  = a_ff.sx;
      b_in.sy  = a_ff.sy;
   end

   function automatic logic signed [lsbc_pkg::COORD_BITS-1:0] place(
         input logic signed [DB-1:0] s, input logic [PB-1:0] prod, input logic neg);
      logic [PB-1:0]        rnd;
      logic [DB-1:0]        m;
      logic signed [DB-1:0] v;
      rnd   = prod + (PB'(1) << (lsbc_pkg::FRAC_BITS - 1));
      m     = rnd[lsbc_pkg::FRAC_BITS +: DB];
      v     = neg ? s - $signed(m) : s + $signed(m);
      place = v[lsbc_pkg::COORD_BITS-1:0];
   endfunction

   // stage C: round, offset from start, zero on reject
   always_comb begin
      c_in = '0;
      if (b_ff.ok) begin
         c_in.accepted        = 1'b1;
         c_in.clipped_start_x = place(b_ff.sx, b_ff.p1x, b_ff.nx);
         c_in.clipped_start_y = place(b_ff.sy, b_ff.p1y, b_ff.ny);
         c_in.clipped_end_x   = place(b_ff.sx, b_ff.p2x, b_ff.nx);
         c_in.clipped_end_y   = place(b_ff.sy, b_ff.p2y, b_ff.ny);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid)   a_ff <= a_in;
      if (b_ready && a_valid_ff) b_ff <= b_in;
      if (c_ready && b_valid_ff) c_ff <= c_in;
   end

endmodule

`default_nettype wire

// File: rtl/line_segment_window_clip.sv
// ----------------------------------------------------------------------------
// line_segment_window_clip: Liang-Barsky clip of a 2D segment to a window
// Setup stage, a row of division cells (one quotient bit each, all edges
// side by side), then edge decisions, scaling and the result register.
//
//   channel | dir | beat
//   req_    | in  | segment endpoints (req_type)
//   rsp_    | out | accepted flag and clipped endpoints (rsp_type)
//   csr_    | in  | window register index and value
//
// One segment per cycle while no stage is stalled by rsp_ready; stages: setup, 18 divider cells, 3 tail.
// The divider row sets the depth: one cell per quotient bit.
// Reset clears all valid bits and loads the default window.
// Each stage holds its beat while the next is full, so stalls back up in order.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_window_clip (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire lsbc_pkg::req_type      req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lsbc_pkg::rsp_type           rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire lsbc_pkg::csr_index_type csr_index,
   input  wire logic signed [lsbc_pkg::COORD_BITS-1:0] csr_data
);

   localparam int DB = lsbc_pkg::DIFF_BITS;
   localparam int NC = lsbc_pkg::NUM_CELLS;

   logic signed [lsbc_pkg::COORD_BITS-1:0] x_min_ff, y_min_ff, x_max_ff, y_max_ff;

   // window registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= '0;
         y_min_ff <= '0;
         x_max_ff <= 16'sh7fff;
         y_max_ff <= 16'sh7fff;
      end else if (csr_valid) begin
         case (csr_index)
            lsbc_pkg::REG_X_MIN: x_min_ff <= csr_data;
            lsbc_pkg::REG_Y_MIN: y_min_ff <= csr_data;
            lsbc_pkg::REG_X_MAX: x_max_ff <= csr_data;
            lsbc_pkg::REG_Y_MAX: y_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // setup stage: differences and lane operands
   logic               front_valid_ff;
   lsbc_pkg::item_type front_ff, front_in;
   logic               row_valid [NC+1];
   logic               row_ready [NC+1];
   lsbc_pkg::item_type row_data  [NC+1];

   always_comb begin
      logic signed [DB-1:0] sx, sy, ex, ey, dx, dy;
      sx = DB'(req_data.start_x);
      sy = DB'(req_data.start_y);
      ex = DB'(req_data.end_x);
      ey = DB'(req_data.end_y);
      dx = ex - sx;
      dy = ey - sy;
      front_in.sx = sx;
      front_in.sy = sy;
      front_in.dx = dx;
      front_in.dy = dy;
      front_in.lane[0] = lsbc_pkg::make_lane(-dx, sx - DB'(x_min_ff));
      front_in.lane[1] = lsbc_pkg::make_lane(dx, DB'(x_max_ff) - sx);
      front_in.lane[2] = lsbc_pkg::make_lane(-dy, sy - DB'(y_min_ff));
      front_in.lane[3] = lsbc_pkg::make_lane(dy, DB'(y_max_ff) - sy);
   end

   assign req_ready = !front_valid_ff || row_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (req_ready) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         front_ff <= front_in;
      end
   end

   assign row_valid[0] = front_valid_ff;
   assign row_data[0]  = front_ff;

   // division cell row
   for (genvar k = 0; k < NC; k++) begin : g_cell
      lsbc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (row_valid[k]),
         .in_ready  (row_ready[k]),
         .in_data   (row_data[k]),
         .out_valid (row_valid[k+1]),
         .out_ready (row_ready[k+1]),
         .out_data  (row_data[k+1])
      );
   end

   lsbc_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row_valid[NC]),
      .in_ready  (row_ready[NC]),
      .in_data   (row_data[NC]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the line segment window clipper
// Drives segments and window writes over valid/ready channels with random
// gaps and stalls, predicts every result with a fixed-point clip model and
// compares each result beat field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 22;
   localparam int N_RANDOM  = 900;
   localparam int MAX_CYCLE = 400000;
   localparam longint ONE_U = longint'(1) << lsbc_pkg::FRAC_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   lsbc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   lsbc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   lsbc_pkg::csr_index_type csr_index = lsbc_pkg::REG_X_MIN;
   logic signed [lsbc_pkg::COORD_BITS-1:0] csr_data = '0;

   line_segment_window_clip dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // window copy used for prediction
   longint win_x_min, win_y_min, win_x_max, win_y_max;
   lsbc_pkg::rsp_type clip_queue[$];
   int errors = 0;
   longint cycle = 0;
   logic stim_done = 1'b0;

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("[line_segment_window_clip] ERROR");
         $finish;
      end
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycle, what);
   endtask

   function automatic longint abs_of(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // q/p in Q.FRAC, rounded half away from zero, clamped to [-1, 2]
   function automatic longint edge_ratio(input longint q, input longint p);
      longint aq, ap, m;
      aq = abs_of(q);
      ap = abs_of(p);
      m = ((aq << (lsbc_pkg::FRAC_BITS + 1)) + ap) / (ap << 1);
      if ((q < 0) != (p < 0)) begin
         if (m > ONE_U) m = ONE_U;
         return -m;
      end
      if (m > 2 * ONE_U) m = 2 * ONE_U;
      return m;
   endfunction

   function automatic bit clip_edge(input longint p, input longint q,
                                    inout longint u_in, inout longint u_out);
      longint r;
      if (p < 0) begin
         r = edge_ratio(q, p);
         if (r > u_out) return 0;
         if (r > u_in) u_in = r;
      end else if (p > 0) begin
         r = edge_ratio(q, p);
         if (r < u_in) return 0;
         if (r < u_out) u_out = r;
      end else if (q < 0) begin
         return 0;
      end
      return 1;
   endfunction

   function automatic longint move_along(input longint u, input longint d);
      longint m;
      m = (abs_of(d) * u + (ONE_U >> 1)) >>> lsbc_pkg::FRAC_BITS;
      return d < 0 ? -m : m;
   endfunction

   function automatic lsbc_pkg::rsp_type clip_segment(input lsbc_pkg::req_type s);
      longint sx, sy, dx, dy, u_in, u_out;
      bit ok;
      lsbc_pkg::rsp_type r;
      sx = s.start_x;
      sy = s.start_y;
      dx = longint'(s.end_x) - sx;
      dy = longint'(s.end_y) - sy;
      u_in = 0;
      u_out = ONE_U;
      ok = clip_edge(-dx, sx - win_x_min, u_in, u_out)
         && clip_edge(dx, win_x_max - sx, u_in, u_out)
         && clip_edge(-dy, sy - win_y_min, u_in, u_out)
         && clip_edge(dy, win_y_max - sy, u_in, u_out);
      r = '0;
      if (ok) begin
         r.accepted = 1'b1;
         r.clipped_start_x = lsbc_pkg::COORD_BITS'(sx + move_along(u_in, dx));
         r.clipped_start_y = lsbc_pkg::COORD_BITS'(sy + move_along(u_in, dy));
         r.clipped_end_x = lsbc_pkg::COORD_BITS'(sx + move_along(u_out, dx));
         r.clipped_end_y = lsbc_pkg::COORD_BITS'(sy + move_along(u_out, dy));
      end
      return r;
   endfunction

   // result side: random stalls, in-order compare
   initial begin : sink
      int wait_n;
      lsbc_pkg::rsp_type want;
      @(posedge clock iff !reset);
      forever begin
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock iff rsp_valid);
         if (clip_queue.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            want = clip_queue.pop_front();
            if (rsp_data.accepted !== want.accepted)
               report($sformatf("accepted %b want %b", rsp_data.accepted, want.accepted));
            if (rsp_data.clipped_start_x !== want.clipped_start_x)
               report($sformatf("start_x %0d want %0d", rsp_data.clipped_start_x,
                                want.clipped_start_x));
            if (rsp_data.clipped_start_y !== want.clipped_start_y)
               report($sformatf("start_y %0d want %0d", rsp_data.clipped_start_y,
                                want.clipped_start_y));
            if (rsp_data.clipped_end_x !== want.clipped_end_x)
               report($sformatf("end_x %0d want %0d", rsp_data.clipped_end_x,
                                want.clipped_end_x));
            if (rsp_data.clipped_end_y !== want.clipped_end_y)
               report($sformatf("end_y %0d want %0d", rsp_data.clipped_end_y,
                                want.clipped_end_y));
         end
      end
   end

   // valid drops only for a gap; back-to-back beats keep it high
   task automatic send_segment(input lsbc_pkg::req_type s, input bit use_gap);
      int gap;
      gap = use_gap ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      clip_queue.push_back(clip_segment(s));
      @(posedge clock iff req_ready);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock iff clip_queue.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_window(input lsbc_pkg::csr_index_type idx, input longint v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= lsbc_pkg::COORD_BITS'(v);
      @(posedge clock iff csr_ready);
      case (idx)
         lsbc_pkg::REG_X_MIN: win_x_min = v;
         lsbc_pkg::REG_Y_MIN: win_y_min = v;
         lsbc_pkg::REG_X_MAX: win_x_max = v;
         default:             win_y_max = v;
      endcase
   endtask

   task automatic set_window(input longint x0, input longint y0,
                             input longint x1, input longint y1);
      drain_pipe();
      write_window(lsbc_pkg::REG_X_MIN, x0);
      write_window(lsbc_pkg::REG_Y_MIN, y0);
      write_window(lsbc_pkg::REG_X_MAX, x1);
      write_window(lsbc_pkg::REG_Y_MAX, y1);
      csr_valid <= 1'b0;
   endtask

   function automatic lsbc_pkg::req_type seg(input int a, input int b, input int c,
                                             input int d);
      lsbc_pkg::req_type s;
      s.start_x = lsbc_pkg::COORD_BITS'(a);
      s.start_y = lsbc_pkg::COORD_BITS'(b);
      s.end_x = lsbc_pkg::COORD_BITS'(c);
      s.end_y = lsbc_pkg::COORD_BITS'(d);
      return s;
   endfunction

   function automatic int rand_coord(input int lo, input int hi);
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 1) ? 32767 : -32768;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // directed stimulus; typed-in result where obvious, else predictor
   typedef struct {
      lsbc_pkg::req_type seg;
      bit                typed;
      lsbc_pkg::rsp_type want;
   } row_type;

   initial begin : stimulus
      row_type rows[$];
      lsbc_pkg::rsp_type pred;
      int lo, hi;
      win_x_min = 0; win_y_min = 0; win_x_max = 32767; win_y_max = 32767;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window, extremes, parallel edges, zero length
      rows.push_back('{seg(0, 0, 32767, 32767), 1, '{1'b1, 0, 0, 32767, 32767}});
      rows.push_back('{seg(-32768, -32768, -1, -1), 1, '0});
      rows.push_back('{seg(5, 7, 5, 7), 1, '{1'b1, 5, 7, 5, 7}});
      rows.push_back('{seg(-5, 7, -5, 7), 1, '0});
      rows.push_back('{seg(-100, 50, 100, 50), 1, '{1'b1, 0, 50, 100, 50}});
      rows.push_back('{seg(10, -3, 10, 20), 1, '{1'b1, 10, 0, 10, 20}});
      rows.push_back('{seg(-32768, -32768, 32767, 32767), 0, '0});
      rows.push_back('{seg(32767, -32768, -32768, 32767), 0, '0});
      rows.push_back('{seg(-1, 3, 2, -4), 0, '0});
      rows.push_back('{seg(-3, -3, 1, 1), 0, '0});
      rows.push_back('{seg(32767, 32767, 32767, 32767), 1, '{1'b1, 32767, 32767, 32767, 32767}});
      rows.push_back('{seg(-10, 5, -1, 5), 1, '0});
      foreach (rows[i]) begin
         send_segment(rows[i].seg, 1);
         if (rows[i].typed) begin
            pred = clip_queue[$];
            if (pred !== rows[i].want) report($sformatf("directed row %0d", i));
            clip_queue[$] = rows[i].want;
         end
      end

      // small window with ratio ties, then inverted and full-range windows
      set_window(-10, -10, 10, 10);
      send_segment(seg(-20, 0, 20, 0), 1);
      send_segment(seg(-20, -20, 20, 20), 1);
      send_segment(seg(-30, 10, -10, 10), 1);
      send_segment(seg(-11, 0, -10, 0), 1);
      send_segment(seg(1, 3, 8, 4), 1);
      set_window(10, 10, -10, -10);
      send_segment(seg(0, 0, 0, 0), 1);
      send_segment(seg(-20, -20, 20, 20), 1);
      set_window(-32768, -32768, 32767, 32767);
      send_segment(seg(-32768, 32767, 32767, -32768), 1);
      send_segment(seg(123, -456, 789, 1011), 1);

      // random phases with changing windows
      for (int ph = 0; ph < 9; ph++) begin
         case (ph % 3)
            0: begin lo = -32768; hi = 32767; end
            1: begin lo = -300; hi = 300; end
            default: begin lo = -4000; hi = 4000; end
         endcase
         if (ph == 8)
            set_window(32767, -32768, -32768, 32767);
         else
            set_window(rand_coord(lo, lo / 4), rand_coord(lo, hi / 2),
                       rand_coord(hi / 4, hi), rand_coord(lo / 2, hi));
         for (int i = 0; i < N_RANDOM / 9; i++) begin
            if (i == 50) drain_pipe();
            send_segment(seg(rand_coord(lo, hi), rand_coord(lo, hi),
                             rand_coord(lo, hi), rand_coord(lo, hi)),
                         $urandom_range(0, 3) != 0 && !(i >= 60 && i < 80));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock iff clip_queue.size() == 0);
      repeat (LATENCY + 8) @(posedge clock);
      if (errors == 0)
         $display("[line_segment_window_clip] OK");
      else
         $display("[line_segment_window_clip] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
